// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the bounding sphere block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while rst_n is high.
`define ACBS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true while rst_n is high.
`define ACBS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/acbs_pkg.sv
// Shared constants and types of the bounding sphere block.
package acbs_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int COORD_BITS   = 20;
    localparam int ADDR_BITS    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int COUNT_BITS   = $clog2(MAX_VERTICES + 1);
    localparam int MAG_BITS     = COORD_BITS;
    localparam int SQ_BITS      = 2 * MAG_BITS;
    localparam int DIST_BITS    = 2 * COORD_BITS + 2;
    localparam int ROOT_BITS    = DIST_BITS / 2;
    localparam int RADIUS_BITS  = COORD_BITS + 1;
    localparam int STEP_BITS    = $clog2(ROOT_BITS + 1);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vertex_t;

    localparam coord_t COORD_TOP    = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_BOTTOM = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic busy;
        logic sum_valid;
    } dist_status_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

// File: hw/rtl/acbs_ifs.sv
// Valid/ready channel interfaces for vertex words in and sphere words out.
interface acbs_vertex_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [acbs_pkg::COORD_BITS-1:0] vertex_x;
    logic signed [acbs_pkg::COORD_BITS-1:0] vertex_y;
    logic signed [acbs_pkg::COORD_BITS-1:0] vertex_z;
    logic                                   vertex_present;
    logic                                   last_vertex;

    modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_present, last_vertex,
                    input ready);
    modport sink (input valid, vertex_x, vertex_y, vertex_z, vertex_present, last_vertex,
                  output ready);
endinterface

interface acbs_sphere_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [acbs_pkg::COORD_BITS-1:0]  center_x;
    logic signed [acbs_pkg::COORD_BITS-1:0]  center_y;
    logic signed [acbs_pkg::COORD_BITS-1:0]  center_z;
    logic        [acbs_pkg::RADIUS_BITS-1:0] radius;
    logic                                    overflowed;

    modport source (output valid, center_x, center_y, center_z, radius, overflowed,
                    input ready);
    modport sink (input valid, center_x, center_y, center_z, radius, overflowed,
                  output ready);
endinterface

// File: hw/rtl/acbs_dist.sv
// Three-stage pipeline computing the squared distance of a vertex from the center.
module acbs_dist (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  acbs_pkg::vertex_t               vertex,
    input  acbs_pkg::vertex_t               center,
    output logic [acbs_pkg::DIST_BITS-1:0]  dist_sq,
    output acbs_pkg::dist_status_t          status
);
    import acbs_pkg::*;

    function automatic logic [MAG_BITS-1:0] abs_diff(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] d_neg;
        begin
            d     = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            d_neg = -d;
            return d[COORD_BITS] ? d_neg[MAG_BITS-1:0] : d[MAG_BITS-1:0];
        end
    endfunction

    logic                 v1_reg, v2_reg, v3_reg;
    logic [MAG_BITS-1:0]  mx_reg, my_reg, mz_reg;
    logic [SQ_BITS-1:0]   sx_reg, sy_reg, sz_reg;
    logic [DIST_BITS-1:0] sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= abs_diff(vertex.x, center.x);
        my_reg  <= abs_diff(vertex.y, center.y);
        mz_reg  <= abs_diff(vertex.z, center.z);
        sx_reg  <= mx_reg * mx_reg;
        sy_reg  <= my_reg * my_reg;
        sz_reg  <= mz_reg * mz_reg;
        sum_reg <= DIST_BITS'(sx_reg) + DIST_BITS'(sy_reg) + DIST_BITS'(sz_reg);
    end

    assign dist_sq          = sum_reg;
    assign status.busy      = v1_reg | v2_reg | v3_reg;
    assign status.sum_valid = v3_reg;

endmodule

// File: hw/rtl/acbs_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle, rounded up.
module acbs_sqrt (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [acbs_pkg::DIST_BITS-1:0]   value,
    output logic [acbs_pkg::RADIUS_BITS-1:0] radius,
    output acbs_pkg::sqrt_status_t           status
);
    import acbs_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] steps_reg, steps_next;
    logic [DIST_BITS-1:0] val_reg, val_next;
    logic [ROOT_BITS-1:0] root_reg, root_next;
    logic [ROOT_BITS+1:0] rem_reg, rem_next;

    logic [ROOT_BITS+2:0] rem_sh;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] rem_sub;
    logic                 fits;

    always_comb
    begin
        rem_sh  = {rem_reg[ROOT_BITS:0], val_reg[DIST_BITS-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        fits    = (rem_sh >= trial);
        rem_sub = rem_sh - trial;

        busy_next  = busy_reg;
        done_next  = 1'b0;
        steps_next = steps_reg;
        val_next   = val_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            steps_next = STEP_BITS'(ROOT_BITS);
            val_next   = value;
            root_next  = '0;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            val_next   = {val_reg[DIST_BITS-3:0], 2'b00};
            root_next  = {root_reg[ROOT_BITS-2:0], fits};
            rem_next   = fits ? rem_sub[ROOT_BITS+1:0] : rem_sh[ROOT_BITS+1:0];
            steps_next = steps_reg - 1'b1;
            if (steps_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    // A nonzero remainder means the floor root is short of covering the value.
    assign radius        = RADIUS_BITS'(root_reg) + RADIUS_BITS'(rem_reg != '0);
    assign status.busy   = busy_reg;
    assign status.done   = done_reg;

endmodule

// File: hw/rtl/aabb_center_bounding_sphere_top.sv
// Top level of the bounding sphere block: vertex store, box tracking and control.
// Usage:
// Vertex words arrive on vertex_in (valid/ready). Each word with vertex_present set
// is written into the on-chip vertex memory and widens the running axis-aligned box.
// Once MAX_VERTICES vertices are stored, further vertices are dropped and the set is
// flagged as overflowed. A word with last_vertex set closes the set; that word's own
// vertex is taken in first. The block then computes the center as the floored box
// midpoint, reads every stored vertex back through a three-stage squared distance
// pipeline keeping the largest value, and takes its square root rounded up.
// Loading accepts vertex words back to back. After the closing word, the block
// computes the center, reads the stored vertices back (one read port, one vertex
// per cycle), drains the distance pipeline, runs the bit-serial square root and
// hands the result to the output register. vertex_in.ready is low during that
// computation.
// The sphere word waits in an output register on sphere_out until taken; loading of
// the next set goes on meanwhile, and a finished sphere waits only if the previous
// one is still held by a stalled receiver. An empty set gives center 0 and radius 0.
// Reset clears the set state and the control; no memory clearing is needed since
// only entries below the stored count are ever read.
module aabb_center_bounding_sphere_top (
    input  logic          clk,
    input  logic          rst_n,
    acbs_vertex_if.sink   vertex_in,
    acbs_sphere_if.source sphere_out
);
    import acbs_pkg::*;

    `include "assert_macros.svh"

    localparam logic [2:0] S_LOAD   = 3'd0;
    localparam logic [2:0] S_CENTER = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_SQRT   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    // Floored midpoint: an arithmetic halving of the widened sum.
    function automatic coord_t floor_mid(coord_t a, coord_t b);
        logic signed [COORD_BITS:0] s;
        begin
            s = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
            return s[COORD_BITS:1];
        end
    endfunction

    logic [2:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] rd_idx_reg, rd_idx_next;
    vertex_t               min_reg, min_next;
    vertex_t               max_reg, max_next;
    logic                  ovf_reg, ovf_next;
    vertex_t               center_reg, center_next;
    logic [DIST_BITS-1:0]  best_reg, best_next;
    logic                  rd_valid_reg;
    logic                  out_valid_reg, out_valid_next;
    vertex_t               out_center_reg, out_center_next;
    logic [RADIUS_BITS-1:0] out_radius_reg, out_radius_next;
    logic                  out_ovf_reg, out_ovf_next;

    // Vertex memory: one write port used while loading, one read port used while walking.
    vertex_t               vmem [MAX_VERTICES];
    vertex_t               rd_data_reg;

    vertex_t               vin;
    logic                  in_accept;
    logic                  store_full;
    logic                  store_en;
    logic                  rd_en;
    logic                  sqrt_start;
    logic                  out_load;

    logic [DIST_BITS-1:0]   dist_sq;
    dist_status_t           dist_status;
    logic [RADIUS_BITS-1:0] sqrt_radius;
    sqrt_status_t           sqrt_status;

    assign vin.x = vertex_in.vertex_x;
    assign vin.y = vertex_in.vertex_y;
    assign vin.z = vertex_in.vertex_z;

    assign vertex_in.ready = (state_reg == S_LOAD);
    assign in_accept       = vertex_in.valid && vertex_in.ready;
    assign store_full      = (count_reg == COUNT_BITS'(MAX_VERTICES));
    assign store_en        = in_accept && vertex_in.vertex_present && !store_full;
    assign rd_en           = (state_reg == S_WALK) && (rd_idx_reg < count_reg);
    assign sqrt_start      = (state_reg == S_DRAIN) && !rd_valid_reg && !dist_status.busy;
    assign out_load        = (state_reg == S_FINISH) && (!out_valid_reg || sphere_out.ready);

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            vmem[count_reg[ADDR_BITS-1:0]] <= vin;
        end
        if (rd_en)
        begin
            rd_data_reg <= vmem[rd_idx_reg[ADDR_BITS-1:0]];
        end
    end

    acbs_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .vertex   (rd_data_reg),
        .center   (center_reg),
        .dist_sq  (dist_sq),
        .status   (dist_status)
    );

    acbs_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqrt_start),
        .value  (best_reg),
        .radius (sqrt_radius),
        .status (sqrt_status)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        ovf_next        = ovf_reg;
        center_next     = center_reg;
        best_next       = best_reg;
        out_valid_next  = out_valid_reg && !sphere_out.ready;
        out_center_next = out_center_reg;
        out_radius_next = out_radius_reg;
        out_ovf_next    = out_ovf_reg;

        // The running maximum follows the pipeline output in every state but S_CENTER, which clears it.
        if (dist_status.sum_valid && (dist_sq > best_reg))
        begin
            best_next = dist_sq;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (store_en)
                begin
                    count_next = count_reg + 1'b1;
                    min_next.x = (vin.x < min_reg.x) ? vin.x : min_reg.x;
                    min_next.y = (vin.y < min_reg.y) ? vin.y : min_reg.y;
                    min_next.z = (vin.z < min_reg.z) ? vin.z : min_reg.z;
                    max_next.x = (vin.x > max_reg.x) ? vin.x : max_reg.x;
                    max_next.y = (vin.y > max_reg.y) ? vin.y : max_reg.y;
                    max_next.z = (vin.z > max_reg.z) ? vin.z : max_reg.z;
                end
                if (in_accept && vertex_in.vertex_present && store_full)
                begin
                    ovf_next = 1'b1;
                end
                if (in_accept && vertex_in.last_vertex)
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                if (count_reg == '0)
                begin
                    center_next = '0;
                end
                else
                begin
                    center_next.x = floor_mid(min_reg.x, max_reg.x);
                    center_next.y = floor_mid(min_reg.y, max_reg.y);
                    center_next.z = floor_mid(min_reg.z, max_reg.z);
                end
                best_next   = '0;
                rd_idx_next = '0;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sqrt_start)
                begin
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (sqrt_status.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_center_next = center_reg;
                    out_radius_next = sqrt_radius;
                    out_ovf_next    = ovf_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    min_next        = '{x: COORD_TOP, y: COORD_TOP, z: COORD_TOP};
                    max_next        = '{x: COORD_BOTTOM, y: COORD_BOTTOM, z: COORD_BOTTOM};
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            min_reg       <= '{x: COORD_TOP, y: COORD_TOP, z: COORD_TOP};
            max_reg       <= '{x: COORD_BOTTOM, y: COORD_BOTTOM, z: COORD_BOTTOM};
            ovf_reg       <= 1'b0;
            best_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            ovf_reg       <= ovf_next;
            best_reg      <= best_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        center_reg     <= center_next;
        out_center_reg <= out_center_next;
        out_radius_reg <= out_radius_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign sphere_out.valid      = out_valid_reg;
    assign sphere_out.center_x   = out_center_reg.x;
    assign sphere_out.center_y   = out_center_reg.y;
    assign sphere_out.center_z   = out_center_reg.z;
    assign sphere_out.radius     = out_radius_reg;
    assign sphere_out.overflowed = out_ovf_reg;

    `ACBS_ASSERT(a_write_only_loading, store_en |-> (state_reg == S_LOAD),
        "vertex memory written outside loading")
    `ACBS_ASSERT_NEVER(a_count_bound, count_reg > COUNT_BITS'(MAX_VERTICES),
        "stored count beyond capacity")
    `ACBS_ASSERT(a_sqrt_start_idle, sqrt_start |-> !sqrt_status.busy,
        "square root started while busy")
    `ACBS_ASSERT(a_sum_while_walking,
        dist_status.sum_valid |-> (state_reg == S_WALK || state_reg == S_DRAIN),
        "distance result outside the walk")
    `ACBS_ASSERT(a_out_from_finish, $rose(out_valid_reg) |-> ($past(state_reg) == S_FINISH),
        "sphere word offered without finishing a set")

endmodule

// File: tb/aabb_center_bounding_sphere_top_tb.sv
// Self-checking testbench of the bounding sphere block, with its own sphere predictor.
module aabb_center_bounding_sphere_top_tb;
    import acbs_pkg::*;

    // Run lengths and limits, all in clock cycles or words.
    localparam int RANDOM_WORDS   = 350;
    localparam int FULL_RATE_WORDS = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 20000;

    // How the coordinates of one set are drawn.
    typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EXTREME} coord_style_t;

    // One predicted sphere word.
    typedef struct {
        coord_t                 center_x;
        coord_t                 center_y;
        coord_t                 center_z;
        logic [RADIUS_BITS-1:0] radius;
        logic                   overflowed;
    } sphere_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    acbs_vertex_if vin();
    acbs_sphere_if sout();

    aabb_center_bounding_sphere_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex_in  (vin),
        .sphere_out (sout)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the set that the block is collecting. Only entries below
    // held_count are ever read, just as in the block.
    coord_t  held_coords [MAX_VERTICES][3];
    int      held_count;
    coord_t  box_lo [3];
    coord_t  box_hi [3];
    logic    held_overflow;

    sphere_t expected_spheres [$];
    int      errors = 0;
    int      words_sent = 0;
    int      quiet_cycles = 0;

    // Shared controls of the two handshake sides. idle_on enables random bubbles
    // on both sides; hold_request asks the receiver for one long stall.
    bit      idle_on = 1'b1;
    bit      hold_request = 1'b0;

    function automatic void clear_held_set();
        held_count = 0;
        held_overflow = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = COORD_TOP;
            box_hi[a] = COORD_BOTTOM;
        end
    endfunction

    // Smallest integer whose square is not below v.
    function automatic longint ceil_root(longint v);
        longint r;
        longint trial;
        r = 0;
        for (int b = 22; b >= 0; b--)
        begin
            trial = r | (longint'(1) << b);
            if (trial * trial <= v)
                r = trial;
        end
        if (r * r < v)
            r++;
        return r;
    endfunction

    // Applies one accepted vertex word to the shadow set. A word that closes the
    // set turns into the expected sphere: the floored box midpoint as center and
    // the rounded-up root of the largest squared distance as radius.
    function automatic void absorb_word(coord_t x, coord_t y, coord_t z,
                                        logic present, logic last);
        coord_t  c [3];
        longint  mid [3];
        longint  d;
        longint  d2;
        longint  best;
        sphere_t s;
        c[0] = x;
        c[1] = y;
        c[2] = z;
        if (present)
        begin
            if (held_count < MAX_VERTICES)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    held_coords[held_count][a] = c[a];
                    if (c[a] < box_lo[a])
                        box_lo[a] = c[a];
                    if (c[a] > box_hi[a])
                        box_hi[a] = c[a];
                end
                held_count++;
            end
            else
                held_overflow = 1'b1;
        end
        if (!last)
            return;
        best = 0;
        for (int a = 0; a < 3; a++)
            mid[a] = 0;
        if (held_count != 0)
        begin
            // An arithmetic shift of the signed sum floors toward minus infinity.
            for (int a = 0; a < 3; a++)
                mid[a] = (longint'(box_lo[a]) + longint'(box_hi[a])) >>> 1;
            for (int i = 0; i < held_count; i++)
            begin
                d2 = 0;
                for (int a = 0; a < 3; a++)
                begin
                    d = longint'(held_coords[i][a]) - mid[a];
                    d2 += d * d;
                end
                if (d2 > best)
                    best = d2;
            end
        end
        s.center_x = coord_t'(mid[0]);
        s.center_y = coord_t'(mid[1]);
        s.center_z = coord_t'(mid[2]);
        s.radius = (RADIUS_BITS)'(ceil_root(best));
        s.overflowed = held_overflow;
        expected_spheres.push_back(s);
        clear_held_set();
    endfunction

    function automatic coord_t random_coord();
        return coord_t'($urandom);
    endfunction

    function automatic coord_t pick_coord(coord_style_t style, coord_t base, int spread);
        int off;
        case (style)
            SPREAD_FULL:
                return random_coord();
            SPREAD_CLUSTER:
            begin
                off = int'($urandom_range(0, 2 * spread)) - spread;
                return coord_t'(int'(base) + off);
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return COORD_TOP;
                    1: return COORD_BOTTOM;
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return random_coord();
                endcase
            end
        endcase
    endfunction

    // Offers one vertex word and returns once it is accepted. A random bubble may
    // come first when idling is enabled. Valid is left high so that back-to-back
    // words keep it high without a gap.
    task automatic send_word(input coord_t x, input coord_t y, input coord_t z,
                             input logic present, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            vin.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        vin.valid          <= 1'b1;
        vin.vertex_x       <= x;
        vin.vertex_y       <= y;
        vin.vertex_z       <= z;
        vin.vertex_present <= present;
        vin.last_vertex    <= last;
        do
            @(posedge clk);
        while (vin.ready !== 1'b1);
        absorb_word(x, y, z, present, last);
        if (present || last)
            words_sent++;
    endtask

    // Sends one set of count vertices drawn in one style. A noisy set has words
    // without a vertex scattered through it. A set closed empty ends with a word
    // that carries no vertex, so the box is final before the closing word.
    task automatic send_set(input int count, input bit noisy, input bit close_empty);
        coord_style_t style;
        int           spread;
        coord_t       base_x;
        coord_t       base_y;
        coord_t       base_z;
        logic         closing;
        style  = coord_style_t'($urandom_range(0, 2));
        spread = 1 << $urandom_range(0, 14);
        base_x = random_coord();
        base_y = random_coord();
        base_z = random_coord();
        for (int i = 0; i < count; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_word(random_coord(), random_coord(), random_coord(), 1'b0, 1'b0);
            closing = !close_empty && (i == count - 1);
            send_word(pick_coord(style, base_x, spread), pick_coord(style, base_y, spread),
                      pick_coord(style, base_z, spread), 1'b1, closing);
        end
        if (close_empty || count == 0)
            send_word(random_coord(), random_coord(), random_coord(), 1'b0, 1'b1);
    endtask

    // Directed sets: empty sets, single vertices at both ends of the range, a box
    // spanning the whole range, odd negative sums that must floor, and words
    // without a vertex in the middle of a set.
    task automatic test_empty_and_extreme_sets();
        idle_on = 1'b1;
        send_word(COORD_TOP, COORD_BOTTOM, coord_t'(-1), 1'b0, 1'b1);
        send_word(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1, 1'b1);
        send_word(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1, 1'b1);
        send_word(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1, 1'b0);
        send_word(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1, 1'b0);
        send_word(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 1'b1);
        send_word(random_coord(), random_coord(), random_coord(), 1'b0, 1'b0);
        send_word(coord_t'(-3), coord_t'(0), coord_t'(5), 1'b1, 1'b0);
        send_word(random_coord(), random_coord(), random_coord(), 1'b0, 1'b0);
        send_word(coord_t'(0), coord_t'(-3), coord_t'(-5), 1'b1, 1'b1);
        send_word(COORD_TOP, COORD_BOTTOM, coord_t'(0), 1'b1, 1'b0);
        send_word(COORD_BOTTOM, COORD_TOP, coord_t'(-1), 1'b1, 1'b0);
        send_word(coord_t'(1), coord_t'(-1), COORD_TOP, 1'b1, 1'b1);
        send_word(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 1'b0);
        send_word(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 1'b1);
        send_word(coord_t'(-7), coord_t'(-9), coord_t'(-11), 1'b1, 1'b0);
        send_word(coord_t'(-6), coord_t'(-8), coord_t'(-10), 1'b1, 1'b1);
    endtask

    // One set fills the store exactly, with its farthest vertex in the last
    // entry. A word without a vertex then must not raise the flag, and the
    // vertices after it, the closing one included, are dropped and must not
    // move the box. A small set follows whose flag must be clear again.
    task automatic test_store_capacity();
        idle_on = 1'b1;
        for (int i = 0; i < MAX_VERTICES - 1; i++)
            send_word(pick_coord(SPREAD_CLUSTER, coord_t'(0), 256),
                      pick_coord(SPREAD_CLUSTER, coord_t'(0), 256),
                      pick_coord(SPREAD_CLUSTER, coord_t'(0), 256), 1'b1, 1'b0);
        send_word(COORD_TOP, COORD_TOP, COORD_TOP, 1'b1, 1'b0);
        send_word(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 1'b0);
        send_word(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, 1'b1, 1'b0);
        send_word(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, 1'b1, 1'b1);
        send_word(COORD_BOTTOM, COORD_TOP, COORD_BOTTOM, 1'b1, 1'b0);
        send_word(COORD_TOP, COORD_BOTTOM, COORD_TOP, 1'b1, 1'b1);
    endtask

    // The receiver stalls for a long stretch while sets keep coming. One sphere
    // parks in the output register, the next one finishes behind it, and the
    // block has to hold off its input until the receiver lets go.
    task automatic test_output_back_pressure();
        idle_on = 1'b0;
        hold_request = 1'b1;
        for (int n = 0; n < 8; n++)
            send_set(16, 1'b0, n[0]);
    endtask

    // Random sets of mostly small sizes with occasional larger ones, empty sets,
    // sets closed by a word without a vertex, and scattered stray words. Idling
    // is switched on and off per set so both busy and quiet stretches occur.
    task automatic test_random_sets();
        int start;
        int count;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0: count = 0;
                1: count = $urandom_range(13, 60);
                default: count = $urandom_range(1, 12);
            endcase
            send_set(count, 1'b1, $urandom_range(0, 4) == 0);
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate_sets();
        int start;
        idle_on = 1'b0;
        start = words_sent;
        while (words_sent - start < FULL_RATE_WORDS)
            send_set($urandom_range(1, 10), 1'b0, $urandom_range(0, 3) == 0);
    endtask

    // Receiver side. Each pass drives ready once at a clock edge and then holds
    // it: one long stall on request, short random stalls while idling is on,
    // otherwise ready stays high.
    initial
    begin
        sout.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                sout.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                sout.ready <= 1'b0;
                repeat ($urandom_range(1, 8) - 1) @(posedge clk);
            end
            else
                sout.ready <= 1'b1;
        end
    end

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    // Every sphere word taken is compared with the oldest prediction.
    always @(posedge clk)
    begin
        sphere_t want;
        if (rst_n && sout.valid === 1'b1 && sout.ready === 1'b1)
        begin
            if (expected_spheres.size() == 0)
            begin
                $display("%0t: sphere word with none expected, actual center %0d %0d %0d",
                         $time, sout.center_x, sout.center_y, sout.center_z);
                errors++;
            end
            else
            begin
                want = expected_spheres.pop_front();
                check_field("center_x", want.center_x, sout.center_x);
                check_field("center_y", want.center_y, sout.center_y);
                check_field("center_z", want.center_z, sout.center_z);
                check_field("radius", want.radius, sout.radius);
                check_field("overflowed", want.overflowed, sout.overflowed);
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((vin.valid === 1'b1 && vin.ready === 1'b1) ||
            (sout.valid === 1'b1 && sout.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        vin.valid          <= 1'b0;
        vin.vertex_x       <= '0;
        vin.vertex_y       <= '0;
        vin.vertex_z       <= '0;
        vin.vertex_present <= 1'b0;
        vin.last_vertex    <= 1'b0;
        clear_held_set();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_extreme_sets();
        test_store_capacity();
        test_output_back_pressure();
        test_random_sets();
        test_full_rate_sets();

        // Drain: wait for every predicted sphere, then watch a while longer so
        // that a stray extra word is still caught.
        vin.valid <= 1'b0;
        while (expected_spheres.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/acbs_pkg.sv
hw/rtl/acbs_ifs.sv
hw/rtl/acbs_dist.sv
hw/rtl/acbs_sqrt.sv
hw/rtl/aabb_center_bounding_sphere_top.sv
tb/aabb_center_bounding_sphere_top_tb.sv
